[rtl/dmep_pkg.sv]
`default_nettype none

package dmep_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TARGET_W    = 12;
    localparam int GAIN_W      = 16;
    localparam int COUNT_W     = 32;
    localparam int DUTY_W      = 17;
    localparam int SPEED_W     = 16;
    localparam int SUM_W       = 24;
    localparam int STAGES      = 4;

    localparam logic [DUTY_W-1:0] DUTY_ONE = 17'h10000;

    localparam logic [TARGET_W-1:0] LEFT_TARGET_RST  = 12'd20;
    localparam logic [TARGET_W-1:0] RIGHT_TARGET_RST = 12'd20;
    localparam logic [GAIN_W-1:0]   LEFT_KP_RST      = 16'd20133;
    localparam logic [GAIN_W-1:0]   RIGHT_KP_RST     = 16'd15938;
    localparam logic [GAIN_W-1:0]   GAIN_ZERO        = 16'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEFT_TARGET  = 3'd0,
        REG_RIGHT_TARGET = 3'd1,
        REG_LEFT_KP      = 3'd2,
        REG_LEFT_KI      = 3'd3,
        REG_LEFT_KD      = 3'd4,
        REG_RIGHT_KP     = 3'd5,
        REG_RIGHT_KI     = 3'd6,
        REG_RIGHT_KD     = 3'd7
    } dmep_reg_e;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
    } dmep_wheel_cfg_t;

    typedef struct packed {
        logic              adv;
        logic              fire;
        logic [STAGES-1:0] vld;
    } dmep_stage_ctl_t;

endpackage

`default_nettype wire

[rtl/dmep_in_if.sv]
`default_nettype none

interface dmep_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;

    modport source (output valid, left_count, right_count, input ready);
    modport sink   (input valid, left_count, right_count, output ready);
endinterface

`default_nettype wire

[rtl/dmep_out_if.sv]
`default_nettype none

interface dmep_out_if;
    logic               valid;
    logic               ready;
    logic        [16:0] left_drive;
    logic        [16:0] right_drive;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               counts_wrapped;

    modport source (output valid, left_drive, right_drive, left_speed, right_speed,
                    counts_wrapped, input ready);
    modport sink   (input valid, left_drive, right_drive, left_speed, right_speed,
                    counts_wrapped, output ready);
endinterface

`default_nettype wire

[rtl/dmep_cfg.sv]
`default_nettype none

module dmep_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [dmep_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [dmep_pkg::CFG_DATA_W-1:0]  wr_data,
    output dmep_pkg::dmep_wheel_cfg_t             left_cfg,
    output dmep_pkg::dmep_wheel_cfg_t             right_cfg
);
    import dmep_pkg::*;

    dmep_wheel_cfg_t left_reg;
    dmep_wheel_cfg_t right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg.target  <= LEFT_TARGET_RST;
            left_reg.kp      <= LEFT_KP_RST;
            left_reg.ki      <= GAIN_ZERO;
            left_reg.kd      <= GAIN_ZERO;
            right_reg.target <= RIGHT_TARGET_RST;
            right_reg.kp     <= RIGHT_KP_RST;
            right_reg.ki     <= GAIN_ZERO;
            right_reg.kd     <= GAIN_ZERO;
        end
        else if (wr_en)
        begin
            case (dmep_reg_e'(wr_index))
                REG_LEFT_TARGET:  left_reg.target  <= wr_data[TARGET_W-1:0];
                REG_RIGHT_TARGET: right_reg.target <= wr_data[TARGET_W-1:0];
                REG_LEFT_KP:      left_reg.kp      <= wr_data;
                REG_LEFT_KI:      left_reg.ki      <= wr_data;
                REG_LEFT_KD:      left_reg.kd      <= wr_data;
                REG_RIGHT_KP:     right_reg.kp     <= wr_data;
                REG_RIGHT_KI:     right_reg.ki     <= wr_data;
                REG_RIGHT_KD:     right_reg.kd     <= wr_data;
                default:          ;
            endcase
        end
    end

    assign left_cfg  = left_reg;
    assign right_cfg = right_reg;

endmodule

`default_nettype wire

[rtl/dmep_lane.sv]
`default_nettype none

module dmep_lane
#(
    parameter int GAIN_SHIFT = 8
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dmep_pkg::dmep_stage_ctl_t           ctl,
    input  wire dmep_pkg::dmep_wheel_cfg_t           wcfg,
    input  wire logic signed [dmep_pkg::COUNT_W-1:0] count,
    input  wire logic                                wrap,
    output logic signed [dmep_pkg::SPEED_W-1:0]      speed,
    output logic        [dmep_pkg::DUTY_W-1:0]       drive
);
    import dmep_pkg::*;

    // stage 1: delta and error
    logic signed [COUNT_W-1:0] last_count_reg;
    logic signed [15:0]        s1_delta_reg;
    logic signed [15:0]        s1_err_reg;
    logic signed [32:0]        delta_full;
    logic signed [15:0]        delta_sat;
    logic signed [17:0]        err_full;
    logic signed [15:0]        err_sat;

    // stage 2: integral and difference
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [15:0]        prev_err_reg;
    logic signed [15:0]        s2_delta_reg;
    logic signed [15:0]        s2_err_reg;
    logic signed [16:0]        s2_diff_reg;
    logic signed [SUM_W-1:0]   s2_sum_reg;
    logic signed [SUM_W:0]     sum_full;
    logic signed [16:0]        diff;

    // stage 3: products
    logic signed [15:0]        s3_delta_reg;
    logic signed [32:0]        s3_pp_reg;
    logic signed [40:0]        s3_pi_reg;
    logic signed [33:0]        s3_pd_reg;
    logic signed [32:0]        pp;
    logic signed [40:0]        pi;
    logic signed [33:0]        pd;

    // stage 4: increment
    logic signed [15:0]        s4_delta_reg;
    logic signed [41:0]        s4_inc_reg;
    logic signed [41:0]        acc;

    // duty
    logic        [DUTY_W-1:0]  duty_reg;
    logic        [DUTY_W-1:0]  duty_next;
    logic signed [42:0]        duty_full;

    always_comb
    begin
        delta_full = {count[COUNT_W-1], count} - {last_count_reg[COUNT_W-1], last_count_reg};
        if (delta_full > 33'sd32767)
            delta_sat = 16'sh7FFF;
        else if (delta_full < -33'sd32768)
            delta_sat = 16'sh8000;
        else
            delta_sat = delta_full[15:0];

        err_full = $signed({6'd0, wcfg.target}) - {{2{delta_sat[15]}}, delta_sat};
        if (err_full > 18'sd32767)
            err_sat = 16'sh7FFF;
        else if (err_full < -18'sd32768)
            err_sat = 16'sh8000;
        else
            err_sat = err_full[15:0];
    end

    always_comb
    begin
        sum_full = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W-15){s1_err_reg[15]}}, s1_err_reg};
        if (sum_full > 25'sd8388607)
            sum_next = 24'sh7FFFFF;
        else if (sum_full < -25'sd8388608)
            sum_next = 24'sh800000;
        else
            sum_next = sum_full[SUM_W-1:0];
        diff = {s1_err_reg[15], s1_err_reg} - {prev_err_reg[15], prev_err_reg};
    end

    always_comb
    begin
        pp = $signed({1'b0, wcfg.kp}) * s2_err_reg;
        pi = $signed({1'b0, wcfg.ki}) * s2_sum_reg;
        pd = $signed({1'b0, wcfg.kd}) * s2_diff_reg;
    end

    always_comb
    begin
        acc = {{9{s3_pp_reg[32]}}, s3_pp_reg} + {s3_pi_reg[40], s3_pi_reg}
            + {{8{s3_pd_reg[33]}}, s3_pd_reg};
    end

    always_comb
    begin
        duty_full = $signed({26'd0, duty_reg}) + {s4_inc_reg[41], s4_inc_reg};
        if (duty_full < 43'sd0)
            duty_next = '0;
        else if (duty_full > 43'sd65536)
            duty_next = DUTY_ONE;
        else
            duty_next = duty_full[DUTY_W-1:0];
    end

    // state, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            sum_reg        <= '0;
            prev_err_reg   <= '0;
            duty_reg       <= '0;
        end
        else if (ctl.adv)
        begin
            if (ctl.fire)
                last_count_reg <= wrap ? '0 : count;
            if (ctl.vld[0])
            begin
                sum_reg      <= sum_next;
                prev_err_reg <= s1_err_reg;
            end
            if (ctl.vld[3])
                duty_reg <= duty_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            if (ctl.fire)
            begin
                s1_delta_reg <= delta_sat;
                s1_err_reg   <= err_sat;
            end
            if (ctl.vld[0])
            begin
                s2_delta_reg <= s1_delta_reg;
                s2_err_reg   <= s1_err_reg;
                s2_diff_reg  <= diff;
                s2_sum_reg   <= sum_next;
            end
            if (ctl.vld[1])
            begin
                s3_delta_reg <= s2_delta_reg;
                s3_pp_reg    <= pp;
                s3_pi_reg    <= pi;
                s3_pd_reg    <= pd;
            end
            if (ctl.vld[2])
            begin
                s4_delta_reg <= s3_delta_reg;
                s4_inc_reg   <= acc >>> GAIN_SHIFT;
            end
        end
    end

    assign speed = s4_delta_reg;
    assign drive = DUTY_ONE - duty_next;

endmodule

`default_nettype wire

[rtl/dual_motor_encoder_pid_speed_unit.sv]
// an accepted input beat passes through the lane stages and then the output register to its result beat
// throughput: one beat per cycle; the pipeline holds while a result waits
// both wheels run in parallel lanes with registered multipliers
// reset: wheel state cleared to zero, registers to their defaults, pipeline empty
`default_nettype none

module dual_motor_encoder_pid_speed_unit
#(
    parameter int COUNT_WRAP_LIMIT = 500000,
    parameter int GAIN_SHIFT       = 8
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    dmep_in_if.sink                               sample,
    dmep_out_if.source                            result,
    input  wire logic                             wr_en,
    input  wire logic [dmep_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [dmep_pkg::CFG_DATA_W-1:0]  wr_data
);
    import dmep_pkg::*;

    localparam logic signed [COUNT_W-1:0] WRAP_LIM = COUNT_W'(COUNT_WRAP_LIMIT);

    dmep_wheel_cfg_t   left_cfg;
    dmep_wheel_cfg_t   right_cfg;
    dmep_stage_ctl_t   ctl;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] wrap_reg;
    logic              wrap;
    logic              out_valid_reg;
    logic              adv;

    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic        [DUTY_W-1:0]  left_drive;
    logic        [DUTY_W-1:0]  right_drive;

    logic        [DUTY_W-1:0]  left_drive_reg;
    logic        [DUTY_W-1:0]  right_drive_reg;
    logic signed [SPEED_W-1:0] left_speed_reg;
    logic signed [SPEED_W-1:0] right_speed_reg;
    logic                      wrapped_reg;

    assign adv  = !out_valid_reg || result.ready;
    assign wrap = (sample.left_count > WRAP_LIM) || (sample.right_count > WRAP_LIM);

    assign ctl.adv  = adv;
    assign ctl.fire = sample.valid && adv;
    assign ctl.vld  = vld_reg;

    assign sample.ready = adv;

    dmep_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .left_cfg  (left_cfg),
        .right_cfg (right_cfg)
    );

    dmep_lane #(.GAIN_SHIFT(GAIN_SHIFT)) u_left
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .wcfg  (left_cfg),
        .count (sample.left_count),
        .wrap  (wrap),
        .speed (left_speed),
        .drive (left_drive)
    );

    dmep_lane #(.GAIN_SHIFT(GAIN_SHIFT)) u_right
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .wcfg  (right_cfg),
        .count (sample.right_count),
        .wrap  (wrap),
        .speed (right_speed),
        .drive (right_drive)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], ctl.fire};
            out_valid_reg <= vld_reg[STAGES-1];
        end
    end

    // merge both lanes into the result beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrap_reg <= {wrap_reg[STAGES-2:0], wrap};
            if (vld_reg[STAGES-1])
            begin
                left_drive_reg  <= left_drive;
                right_drive_reg <= right_drive;
                left_speed_reg  <= left_speed;
                right_speed_reg <= right_speed;
                wrapped_reg     <= wrap_reg[STAGES-1];
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.left_drive     = left_drive_reg;
    assign result.right_drive    = right_drive_reg;
    assign result.left_speed     = left_speed_reg;
    assign result.right_speed    = right_speed_reg;
    assign result.counts_wrapped = wrapped_reg;

endmodule

`default_nettype wire
